// ===== hw/rtl/ycc420_pkg.sv =====
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
package ycc420_pkg;

  localparam int CFG_W        = 13;
  localparam int ROW_W        = 12;
  localparam int PIX_W        = 8;
  localparam int SUM_W        = 9;
  localparam int ENTRY_W      = 3 * SUM_W;
  localparam int AVG_W        = 10;
  localparam int LUMA_PROD_W  = 21;
  localparam int CHR_PROD_W   = 20;
  localparam int CHR_SUM_W    = 22;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT       = 13'd4096;
  localparam logic [CFG_W-1:0] MIN_SIZE           = 13'd2;

  localparam logic [LUMA_PROD_W-1:0] Y_COEF_R    = 21'd2104;
  localparam logic [LUMA_PROD_W-1:0] Y_COEF_G    = 21'd4130;
  localparam logic [LUMA_PROD_W-1:0] Y_COEF_B    = 21'd802;
  localparam logic [LUMA_PROD_W-1:0] LUMA_OFFSET = 21'd135168;

  localparam logic [CHR_PROD_W-1:0] CB_COEF_R = 20'd1214;
  localparam logic [CHR_PROD_W-1:0] CB_COEF_G = 20'd2384;
  localparam logic [CHR_PROD_W-1:0] CB_COEF_B = 20'd3598;
  localparam logic [CHR_PROD_W-1:0] CR_COEF_R = 20'd3598;
  localparam logic [CHR_PROD_W-1:0] CR_COEF_G = 20'd3013;
  localparam logic [CHR_PROD_W-1:0] CR_COEF_B = 20'd585;
  localparam logic [CHR_SUM_W-1:0]  CHROMA_OFFSET = 22'd1052672;

  localparam logic [PIX_W-1:0] LUMA_MAX   = 8'd235;
  localparam logic [SUM_W-1:0] CHROMA_MIN = 9'd16;
  localparam logic [SUM_W-1:0] CHROMA_MAX = 9'd240;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

// ===== hw/rtl/ycc420_if.sv =====
// Request channels of the converter: RGB pixel in, YCbCr result out.
interface ycc420_pixel_if import ycc420_pkg::*; ();
  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ycc420_result_if import ycc420_pkg::*; ();
  logic valid;
  logic ready;
  pix_t luma;
  logic chroma_valid;
  pix_t cb_value;
  pix_t cr_value;
  logic frame_end;
  modport source (output valid, output luma, output chroma_valid, output cb_value,
                  output cr_value, output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input cb_value,
                  input cr_value, input frame_end, output ready);
endinterface

// ===== hw/rtl/rgb_to_ycbcr420_converter_unit.sv =====
// RGB to YCbCr 4:2:0 converter, BT.601 limited range, top level.
//
// in_pixel takes one RGB pixel per request in raster order; out_result
// gives one request per pixel: luma always, and on the second pixel of each
// pair on odd rows also the 2x2 averaged Cb and Cr with chroma_valid set.
// frame_end marks the last pixel of the frame. Frame size comes from the
// cfg_ write port (index 0 width, index 1 height); write it only while idle.
// A line memory of MAX_WIDTH/2 entries keeps the pair sums of each even row;
// it is read once per pair on the following odd row.
// Throughput is one pixel per cycle while out_result takes results; an accepted
// pixel passes three pipeline stages (line memory read beside stage 1, the
// multiplier products in stages 2 and 3) and then the output register.
// When out_result stalls the stages fill up and in_pixel.ready drops once
// all four slots hold a result; nothing is lost or repeated.
// Reset clears the counters, the held pixel and the stage valids and loads
// a 640x480 frame size; the line memory needs no clearing pass.
module rgb_to_ycbcr420_converter_unit
  import ycc420_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ycc420_pixel_if.sink           in_pixel,
  ycc420_result_if.source        out_result,
  input  logic                   cfg_wr_en,
  input  cfg_index_t             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SIZE_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

  logic [CFG_W-1:0]  frame_width_r, frame_height_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [3*PIX_W-1:0] held_r;

  logic [ENTRY_W-1:0] line_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  logic v1_r, v2_r, v3_r, out_v_r;
  logic v1_nxt, v2_nxt, v3_nxt, out_v_nxt;
  logic out_load, s3_load, s2_load, accept;

  logic [SIZE_W-1:0] width_even, eff_w, col_inc;
  logic [CFG_W-1:0]  height_even, eff_h, row_inc;
  logic              row_done, frame_done, col_odd, row_odd;
  logic [ADDR_W-1:0] mem_addr;
  sum_t              sum_r_c, sum_g_c, sum_b_c;

  // stage 1
  pix_t s1_red_r, s1_green_r, s1_blue_r;
  sum_t s1_sr_r, s1_sg_r, s1_sb_r;
  logic s1_chroma_r, s1_fend_r;
  // stage 2
  logic [LUMA_PROD_W-1:0] s2_yr_r, s2_yg_r, s2_yb_r;
  pix_t s2_ar_r, s2_ag_r, s2_ab_r;
  logic s2_chroma_r, s2_fend_r;
  logic [AVG_W-1:0] avg_r_c, avg_g_c, avg_b_c;
  // stage 3
  pix_t s3_luma_r;
  logic [CHR_PROD_W-1:0] s3_bu_r, s3_bv_r, s3_bw_r, s3_ru_r, s3_rv_r, s3_rw_r;
  logic s3_chroma_r, s3_fend_r;
  logic [LUMA_PROD_W-1:0] luma_sum;
  pix_t luma_c;
  // output
  pix_t out_luma_r, out_cb_r, out_cr_r;
  logic out_chroma_r, out_fend_r;
  logic [CHR_SUM_W-1:0] cb_sum, cr_sum;
  sum_t cb_raw, cr_raw;
  pix_t cb_c, cr_c;

  // Handshake and stage advance
  always_comb begin
    out_load = v3_r && (!out_v_r || out_result.ready);
    s3_load  = v2_r && (!v3_r || out_load);
    s2_load  = v1_r && (!v2_r || s3_load);
    in_pixel.ready = rst_n && (!v1_r || s2_load);
    accept   = in_pixel.valid && in_pixel.ready;

    v1_nxt    = accept   ? 1'b1 : (s2_load ? 1'b0 : v1_r);
    v2_nxt    = s2_load  ? 1'b1 : (s3_load ? 1'b0 : v2_r);
    v3_nxt    = s3_load  ? 1'b1 : (out_load ? 1'b0 : v3_r);
    out_v_nxt = out_load ? 1'b1 : (out_result.ready ? 1'b0 : out_v_r);
  end

  // Effective frame size and raster position
  always_comb begin
    width_even = SIZE_W'({frame_width_r[CFG_W-1:1], 1'b0});
    if (width_even < SIZE_W'(MIN_SIZE)) begin
      eff_w = SIZE_W'(MIN_SIZE);
    end else if (width_even > SIZE_W'(MAX_WIDTH)) begin
      eff_w = SIZE_W'(MAX_WIDTH);
    end else begin
      eff_w = width_even;
    end
    height_even = {frame_height_r[CFG_W-1:1], 1'b0};
    if (height_even < MIN_SIZE) begin
      eff_h = MIN_SIZE;
    end else if (height_even > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = height_even;
    end

    col_inc    = SIZE_W'(col_r) + SIZE_W'(1);
    row_inc    = CFG_W'(row_r) + CFG_W'(1);
    row_done   = col_inc >= eff_w;
    frame_done = row_done && (row_inc >= eff_h);
    col_odd    = col_r[0];
    row_odd    = row_r[0];
    mem_addr   = ADDR_W'(col_r >> 1);

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_done) begin
        col_nxt = '0;
        row_nxt = frame_done ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end

    sum_r_c = SUM_W'(in_pixel.red)   + SUM_W'(held_r[3*PIX_W-1:2*PIX_W]);
    sum_g_c = SUM_W'(in_pixel.green) + SUM_W'(held_r[2*PIX_W-1:PIX_W]);
    sum_b_c = SUM_W'(in_pixel.blue)  + SUM_W'(held_r[PIX_W-1:0]);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_FRAME_WIDTH;
      frame_height_r <= RESET_FRAME_HEIGHT;
      col_r          <= '0;
      row_r          <= '0;
      held_r         <= '0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      v3_r           <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
          default: ;
        endcase
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      v3_r    <= v3_nxt;
      out_v_r <= out_v_nxt;
      if (accept && !col_odd) begin
        held_r <= {in_pixel.red, in_pixel.green, in_pixel.blue};
      end
    end
  end

  // Line memory: write pair sums on even rows, read them back on odd rows
  always_ff @(posedge clk) begin
    if (accept && col_odd && !row_odd) begin
      line_mem[mem_addr] <= {sum_r_c, sum_g_c, sum_b_c};
    end
    if (accept && col_odd && row_odd) begin
      rd_data_r <= line_mem[mem_addr];
    end
  end

  // Stage 1: capture pixel, pair sums and flags
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red_r    <= in_pixel.red;
      s1_green_r  <= in_pixel.green;
      s1_blue_r   <= in_pixel.blue;
      s1_sr_r     <= sum_r_c;
      s1_sg_r     <= sum_g_c;
      s1_sb_r     <= sum_b_c;
      s1_chroma_r <= col_odd && row_odd;
      s1_fend_r   <= frame_done;
    end
  end

  // Stage 2: luma products and 2x2 averages
  always_comb begin
    avg_r_c = AVG_W'(s1_sr_r) + AVG_W'(rd_data_r[3*SUM_W-1:2*SUM_W]) + AVG_W'(2);
    avg_g_c = AVG_W'(s1_sg_r) + AVG_W'(rd_data_r[2*SUM_W-1:SUM_W]) + AVG_W'(2);
    avg_b_c = AVG_W'(s1_sb_r) + AVG_W'(rd_data_r[SUM_W-1:0]) + AVG_W'(2);
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_yr_r     <= LUMA_PROD_W'(s1_red_r) * Y_COEF_R;
      s2_yg_r     <= LUMA_PROD_W'(s1_green_r) * Y_COEF_G;
      s2_yb_r     <= LUMA_PROD_W'(s1_blue_r) * Y_COEF_B;
      s2_ar_r     <= avg_r_c[AVG_W-1:2];
      s2_ag_r     <= avg_g_c[AVG_W-1:2];
      s2_ab_r     <= avg_b_c[AVG_W-1:2];
      s2_chroma_r <= s1_chroma_r;
      s2_fend_r   <= s1_fend_r;
    end
  end

  // Stage 3: luma sum and clamp, chroma products
  always_comb begin
    luma_sum = s2_yr_r + s2_yg_r + s2_yb_r + LUMA_OFFSET;
    luma_c   = (luma_sum[LUMA_PROD_W-1:13] > LUMA_MAX) ? LUMA_MAX : luma_sum[LUMA_PROD_W-1:13];
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_luma_r   <= luma_c;
      s3_bu_r     <= CHR_PROD_W'(s2_ar_r) * CB_COEF_R;
      s3_bv_r     <= CHR_PROD_W'(s2_ag_r) * CB_COEF_G;
      s3_bw_r     <= CHR_PROD_W'(s2_ab_r) * CB_COEF_B;
      s3_ru_r     <= CHR_PROD_W'(s2_ar_r) * CR_COEF_R;
      s3_rv_r     <= CHR_PROD_W'(s2_ag_r) * CR_COEF_G;
      s3_rw_r     <= CHR_PROD_W'(s2_ab_r) * CR_COEF_B;
      s3_chroma_r <= s2_chroma_r;
      s3_fend_r   <= s2_fend_r;
    end
  end

  // Output stage: chroma sums, shift and clamp
  always_comb begin
    cb_sum = CHR_SUM_W'(s3_bw_r) + CHROMA_OFFSET - CHR_SUM_W'(s3_bu_r) - CHR_SUM_W'(s3_bv_r);
    cr_sum = CHR_SUM_W'(s3_ru_r) + CHROMA_OFFSET - CHR_SUM_W'(s3_rv_r) - CHR_SUM_W'(s3_rw_r);
    cb_raw = cb_sum[CHR_SUM_W-1:13];
    cr_raw = cr_sum[CHR_SUM_W-1:13];
    priority if (cb_raw < CHROMA_MIN) begin
      cb_c = PIX_W'(CHROMA_MIN);
    end else if (cb_raw > CHROMA_MAX) begin
      cb_c = PIX_W'(CHROMA_MAX);
    end else begin
      cb_c = cb_raw[PIX_W-1:0];
    end
    priority if (cr_raw < CHROMA_MIN) begin
      cr_c = PIX_W'(CHROMA_MIN);
    end else if (cr_raw > CHROMA_MAX) begin
      cr_c = PIX_W'(CHROMA_MAX);
    end else begin
      cr_c = cr_raw[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_luma_r   <= s3_luma_r;
      out_chroma_r <= s3_chroma_r;
      out_cb_r     <= s3_chroma_r ? cb_c : '0;
      out_cr_r     <= s3_chroma_r ? cr_c : '0;
      out_fend_r   <= s3_fend_r;
    end
  end

  assign out_result.valid        = out_v_r;
  assign out_result.luma         = out_luma_r;
  assign out_result.chroma_valid = out_chroma_r;
  assign out_result.cb_value     = out_cb_r;
  assign out_result.cr_value     = out_cr_r;
  assign out_result.frame_end    = out_fend_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: random RGB frames through the converter against a YCbCr predictor.
module tb;
  import ycc420_pkg::*;

  localparam int MAX_W        = 4096;
  localparam int PIPE_DEPTH   = 4;
  localparam int RAND_PIXELS  = 1050;
  localparam int CALM_PIXELS  = 200;
  localparam int WIDE_PIXELS  = 256;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  typedef struct packed {
    pix_t luma;
    logic chroma_valid;
    pix_t cb_value;
    pix_t cr_value;
    logic frame_end;
  } ycc_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_wr_en = 1'b0;
  cfg_index_t       cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             pix_valid = 1'b0;
  rgb_t             pix_rgb   = '0;
  logic             res_ready = 1'b0;
  logic             pix_fire  = 1'b0;
  bit               idle_on   = 1'b1;
  int               src_gap   = 0;
  int               snk_gap   = 0;
  int               fail_count    = 0;
  int unsigned      pixels_queued = 0;

  rgb_t pixel_q[$];
  ycc_t ycc_expect_q[$];

  logic [CFG_W-1:0]   width_reg     = RESET_FRAME_WIDTH;
  logic [CFG_W-1:0]   height_reg    = RESET_FRAME_HEIGHT;
  rgb_t               first_of_pair = '0;
  int unsigned        pred_col      = 0;
  int unsigned        pred_row      = 0;
  logic [ENTRY_W-1:0] pair_sums [MAX_W/2];

  ycc420_pixel_if  pix_if ();
  ycc420_result_if res_if ();

  assign pix_if.valid = pix_valid;
  assign pix_if.red   = pix_rgb.red;
  assign pix_if.green = pix_rgb.green;
  assign pix_if.blue  = pix_rgb.blue;
  assign res_if.ready = res_ready;

  rgb_to_ycbcr420_converter_unit #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pixel   (pix_if.sink),
    .out_result (res_if.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned limit);
    int unsigned s;
    s = 32'({v[CFG_W-1:1], 1'b0});
    if (s < 2) begin
      s = 2;
    end
    if (s > limit) begin
      s = limit;
    end
    return s;
  endfunction

  function automatic pix_t clamp_chroma(int v);
    if (v < 16) begin
      return 8'd16;
    end
    if (v > 240) begin
      return 8'd240;
    end
    return pix_t'(v);
  endfunction

  function automatic pix_t rand_component();
    case ($urandom_range(0, 9))
      0: begin
        return 8'd0;
      end
      1: begin
        return 8'd255;
      end
      default: begin
        return pix_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t p;
    p.red   = rand_component();
    p.green = rand_component();
    p.blue  = rand_component();
    return p;
  endfunction

  function automatic int unsigned frame_pixels_left();
    int unsigned w, h, n;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, int'(HEIGHT_LIMIT));
    n = (pred_col + 1 >= w) ? 1 : w - pred_col;
    if (pred_row + 1 < h) begin
      n += (h - pred_row - 1) * w;
    end
    return n;
  endfunction

  // a wider row may only start on an even row, or the odd row reads unwritten sums
  function automatic bit width_change_safe(logic [CFG_W-1:0] val);
    return pred_row[0] == 1'b0 || eff_size(val, MAX_W) <= eff_size(width_reg, MAX_W);
  endfunction

  task automatic predict_pixel(input rgb_t px);
    int unsigned w, h, idx;
    int y, sr, sg, sb, ar, ag, ab;
    logic [ENTRY_W-1:0] entry;
    ycc_t res;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, int'(HEIGHT_LIMIT));
    res = '0;
    y = (2104 * int'(px.red) + 4130 * int'(px.green) + 802 * int'(px.blue) + 135168) >>> 13;
    res.luma = (y > 235) ? 8'd235 : pix_t'(y);
    if (pred_col[0] == 1'b0) begin
      first_of_pair = px;
    end else begin
      sr = int'(px.red) + int'(first_of_pair.red);
      sg = int'(px.green) + int'(first_of_pair.green);
      sb = int'(px.blue) + int'(first_of_pair.blue);
      idx = pred_col >> 1;
      if (pred_row[0] == 1'b0) begin
        pair_sums[idx] = {sr[SUM_W-1:0], sg[SUM_W-1:0], sb[SUM_W-1:0]};
      end else begin
        entry = pair_sums[idx];
        ar = (sr + int'(entry[2*SUM_W +: SUM_W]) + 2) >>> 2;
        ag = (sg + int'(entry[SUM_W +: SUM_W]) + 2) >>> 2;
        ab = (sb + int'(entry[0 +: SUM_W]) + 2) >>> 2;
        res.cb_value = clamp_chroma((-1214 * ar - 2384 * ag + 3598 * ab + 1052672) >>> 13);
        res.cr_value = clamp_chroma((3598 * ar - 3013 * ag - 585 * ab + 1052672) >>> 13);
        res.chroma_valid = 1'b1;
      end
    end
    if (pred_col + 1 >= w) begin
      pred_col = 0;
      if (pred_row + 1 >= h) begin
        pred_row = 0;
        res.frame_end = 1'b1;
      end else begin
        pred_row++;
      end
    end else begin
      pred_col++;
    end
    ycc_expect_q.push_back(res);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      pix_valid <= 1'b0;
      src_gap = 0;
    end else if (pix_valid && !pix_fire) begin
      // hold the pending request
    end else if (src_gap != 0) begin
      src_gap--;
      pix_valid <= 1'b0;
    end else if (pixel_q.size() == 0) begin
      pix_valid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      src_gap = $urandom_range(0, 18);
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= 1'b1;
      pix_rgb   <= pixel_q.pop_front();
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      snk_gap = 0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      res_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      snk_gap = $urandom_range(0, 18);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ycc_t got, want;
    if (!rst_n) begin
      pix_fire <= 1'b0;
    end else begin
      if (res_if.valid && res_ready) begin
        got = {res_if.luma, res_if.chroma_valid, res_if.cb_value, res_if.cr_value,
               res_if.frame_end};
        if (ycc_expect_q.size() == 0) begin
          fail_count++;
          $error("result with no pending pixel: luma %0d", got.luma);
        end else begin
          want = ycc_expect_q.pop_front();
          check_field("luma", want.luma, got.luma);
          check_field("chroma_valid", want.chroma_valid, got.chroma_valid);
          check_field("cb_value", want.cb_value, got.cb_value);
          check_field("cr_value", want.cr_value, got.cr_value);
          check_field("frame_end", want.frame_end, got.frame_end);
        end
      end
      pix_fire <= pix_valid && pix_if.ready;
      if (pix_valid && pix_if.ready) begin
        predict_pixel(pix_rgb);
      end
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() != 0 || pix_valid || ycc_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
    @(negedge clk);
  endtask

  task automatic push_pixels(input int unsigned n);
    repeat (n) begin
      pixel_q.push_back(rand_pixel());
      pixels_queued++;
    end
  endtask

  initial begin
    int unsigned rand_start;
    logic [CFG_W-1:0] new_w;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    pixel_q.push_back({8'd0, 8'd0, 8'd0});
    pixel_q.push_back({8'd255, 8'd255, 8'd255});
    pixel_q.push_back({8'd255, 8'd0, 8'd0});
    pixel_q.push_back({8'd0, 8'd255, 8'd0});
    wait_idle();
    // shrink mid-row below the current column, odd values crop
    write_reg(CFG_FRAME_WIDTH, 13'd5);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    pixel_q.push_back({8'd0, 8'd255, 8'd255});
    pixel_q.push_back({8'd0, 8'd0, 8'd255});
    pixel_q.push_back({8'd0, 8'd0, 8'd255});
    pixel_q.push_back({8'd255, 8'd0, 8'd0});
    pixel_q.push_back({8'd255, 8'd0, 8'd0});
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    repeat (4) pixel_q.push_back({8'd0, 8'd0, 8'd255});
    repeat (4) pixel_q.push_back({8'd255, 8'd255, 8'd0});
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    push_pixels(3);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    push_pixels(9);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    push_pixels(frame_pixels_left());

    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd4096);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    push_pixels(WIDE_PIXELS);
    wait_idle();
    // end the wide row early, then finish the frame at that width
    write_reg(CFG_FRAME_WIDTH, 13'(WIDE_PIXELS));
    push_pixels(frame_pixels_left());
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd8);
    write_reg(CFG_FRAME_HEIGHT, 13'd4);

    rand_start = pixels_queued;
    while (pixels_queued - rand_start < RAND_PIXELS - CALM_PIXELS) begin
      wait_idle();
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 6) begin
        push_pixels(frame_pixels_left());
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(0, 25)));
        write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(0, 9)));
        push_pixels(frame_pixels_left() * $urandom_range(1, 2));
      end else begin
        push_pixels($urandom_range(1, 30));
        wait_idle();
        new_w = 13'($urandom_range(0, 25));
        if (width_change_safe(new_w)) begin
          write_reg(CFG_FRAME_WIDTH, new_w);
        end
        if ($urandom_range(0, 1) == 1) begin
          write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(0, 9)));
        end
      end
    end

    wait_idle();
    idle_on = 1'b0;
    push_pixels(CALM_PIXELS);

    wait_idle();
    if (fail_count == 0 && ycc_expect_q.size() == 0) begin
      $display("rgb_to_ycbcr420_converter_unit: match");
    end else begin
      $display("rgb_to_ycbcr420_converter_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("rgb_to_ycbcr420_converter_unit: mismatch");
    $finish;
  end

endmodule
